// ===== hw/rtl/zero_crossing_period_tracker_top_macros.svh =====
// ----------------------------------------------------------------------------
// Zero crossing period tracker: assertion macros
// Shared concurrent assertion forms used by the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef ZERO_CROSSING_PERIOD_TRACKER_TOP_MACROS_SVH
`define ZERO_CROSSING_PERIOD_TRACKER_TOP_MACROS_SVH

// Condition must never hold outside reset
`define ZCPT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define ZCPT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ZCPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/zcpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Zero crossing period tracker package
// Shared widths, reset values and configuration register indexes.
// ----------------------------------------------------------------------------
package zcpt_pkg;

    // Default structural parameters
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF    = 16;
    localparam int AVG_FRAC_BITS_DEF = 8;

    // Averaging weight, Q1.16
    localparam int ALPHA_W    = 17;
    localparam int ALPHA_FRAC = 16;
    localparam int ALPHA_HALF = 1 << (ALPHA_FRAC - 1);
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << ALPHA_FRAC);

    // Fixed field widths
    localparam int GAP_W     = 16;
    localparam int CLIP_W    = 16;
    localparam int SUM_W     = 48;
    localparam int CFG_IDX_W = 3;

    // Register reset values
    localparam int ALPHA_RST     = 32768;
    localparam int THRESH_RST    = 256;
    localparam int SLEW_RST      = 256;
    localparam int GAP_LIMIT_RST = 2560;
    localparam int MAX_RUN_RST   = 10;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA     = 3'd0,
        CFG_THRESH    = 3'd1,
        CFG_SLEW      = 3'd2,
        CFG_GAP_LIMIT = 3'd3,
        CFG_MAX_RUN   = 3'd4,
        CFG_METRICS   = 3'd5
    } t_cfg_idx;

endpackage

// ===== hw/rtl/zcpt_avg.sv =====
// ----------------------------------------------------------------------------
// Zero crossing period tracker: period averager
// Holds the smoothed period and the big-gap run; applies one update per
// down crossing (exponential average, slew step or jump).
// ----------------------------------------------------------------------------
`include "zero_crossing_period_tracker_top_macros.svh"

module zcpt_avg
    import zcpt_pkg::*;
#(
    parameter int COUNT_BITS    = COUNT_BITS_DEF,
    parameter int AVG_FRAC_BITS = AVG_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_update,
    input  logic [COUNT_BITS-1:0]               i_period,
    input  logic [ALPHA_W-1:0]                  i_alpha,
    input  logic [COUNT_BITS+AVG_FRAC_BITS-1:0] i_change_threshold,
    input  logic [COUNT_BITS+AVG_FRAC_BITS-1:0] i_slew_step,
    input  logic [COUNT_BITS+AVG_FRAC_BITS-1:0] i_gap_limit,
    input  logic [GAP_W-1:0]                    i_max_gap_run,
    output logic [COUNT_BITS+AVG_FRAC_BITS-1:0] o_avg_next
);

    localparam int AW  = COUNT_BITS + AVG_FRAC_BITS;
    localparam int DW  = AW + 1;
    localparam int PW  = DW + ALPHA_W + 1;
    localparam int FW  = PW - ALPHA_FRAC;
    localparam int SW  = AW + ALPHA_W + 1;
    localparam int STW = SW - ALPHA_FRAC;
    localparam logic [AW-1:0] ONE_Q = AW'(1) << AVG_FRAC_BITS;

    logic [AW-1:0]          r_avg;
    logic [GAP_W-1:0]       r_gap_run;
    logic [AW-1:0]          n_avg;
    logic [GAP_W-1:0]       n_gap_run;

    logic [ALPHA_W-1:0]     alpha_c;
    logic [AW-1:0]          meas;
    logic signed [DW-1:0]   delta;
    logic signed [PW-1:0]   prod;
    logic signed [PW-1:0]   prod_rnd;
    logic signed [FW-1:0]   diff;
    logic signed [FW-1:0]   thr_s;
    logic                   up_jump;
    logic                   dn_jump;
    logic [AW-1:0]          avg_ewma;
    logic [SW-2:0]          step_mul;
    logic [SW-1:0]          step_rnd;
    logic [STW-1:0]         stepv;
    logic [STW-1:0]         up_sum;
    logic [AW-1:0]          avg_up;
    logic [AW-1:0]          avg_dn;
    logic [AW-1:0]          avg_sel;
    logic [AW-1:0]          gap_dist;
    logic                   big_gap;
    logic [GAP_W-1:0]       gap_inc;
    logic                   jump;
    logic [AW-1:0]          avg_fin;
    logic [AW-1:0]          avg_upd;

    // Clamp the weight to one and form the measured period in Q.frac
    assign alpha_c = (i_alpha > ALPHA_ONE) ? ALPHA_ONE : i_alpha;
    assign meas    = {i_period, {AVG_FRAC_BITS{1'b0}}};

    // Exponential average as old + alpha * (meas - old), rounded half up
    assign delta    = $signed({1'b0, meas}) - $signed({1'b0, r_avg});
    assign prod     = $signed({1'b0, alpha_c}) * delta;
    assign prod_rnd = prod + PW'(ALPHA_HALF);
    assign diff     = prod_rnd[PW-1:ALPHA_FRAC];
    assign avg_ewma = AW'($signed({3'b000, r_avg}) + diff);

    // Detect an update beyond the change threshold in either direction
    assign thr_s   = $signed({3'b000, i_change_threshold});
    assign up_jump = diff > thr_s;
    assign dn_jump = diff < -thr_s;

    // Slew step size alpha * slew_step, rounded half up
    assign step_mul = alpha_c * i_slew_step;
    assign step_rnd = {1'b0, step_mul} + SW'(ALPHA_HALF);
    assign stepv    = step_rnd[SW-1:ALPHA_FRAC];

    // Saturating slew steps
    assign up_sum = STW'({2'b00, r_avg}) + stepv;
    assign avg_up = (|up_sum[STW-1:AW]) ? {AW{1'b1}} : up_sum[AW-1:0];
    assign avg_dn = (STW'({2'b00, r_avg}) > stepv) ?
                    AW'(STW'({2'b00, r_avg}) - stepv) : '0;

    always_comb begin
        if (up_jump) begin
            avg_sel = avg_up;
        end else if (dn_jump) begin
            avg_sel = avg_dn;
        end else begin
            avg_sel = avg_ewma;
        end
    end

    // Track the run of big gaps and jump once it grows past the limit
    assign gap_dist = (meas > avg_sel) ? (meas - avg_sel) : (avg_sel - meas);
    assign big_gap  = gap_dist > i_gap_limit;
    assign gap_inc = (r_gap_run != {GAP_W{1'b1}}) ? (r_gap_run + GAP_W'(1)) : r_gap_run;
    assign jump    = big_gap && (gap_inc > i_max_gap_run);
    assign avg_fin = jump ? meas : avg_sel;
    assign avg_upd = (avg_fin == '0) ? ONE_Q : avg_fin;

    assign n_avg     = i_update ? avg_upd : r_avg;
    assign n_gap_run = i_update ? (big_gap ? gap_inc : '0) : r_gap_run;
    assign o_avg_next = n_avg;

    // Hold average and gap run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg     <= ONE_Q;
            r_gap_run <= '0;
        end else begin
            r_avg     <= n_avg;
            r_gap_run <= n_gap_run;
        end
    end

    `ZCPT_ASSERT_NEVER(a_avg_nonzero, i_clk, i_rst_n, r_avg == '0, "average reached zero")
    `ZCPT_ASSERT_NEXT(a_avg_hold, i_clk, i_rst_n, i_rst_n && !i_update, $stable(r_avg),
        "average moved without a crossing")
    `ZCPT_ASSERT_NEXT(a_gap_clear, i_clk, i_rst_n, i_rst_n && i_update && !big_gap,
        r_gap_run == '0, "gap run not cleared after a small gap")

endmodule

// ===== hw/rtl/zero_crossing_period_tracker_top.sv =====
// Zero crossing period tracker. Takes one signed sample per transaction and
// returns one result per sample: the smoothed period between downward zero
// crossings (unsigned, AVG_FRAC_BITS fraction bits, never zero) plus, on the
// sample that completes a wave and with metrics enabled, the wave's lengths,
// peaks, clip count and sums of squares. A new sample is taken every clock
// unless the result channel stalls; each one passes an input register (where
// its square is formed) and then the result register. The period update at a
// crossing uses two multiplies in the result stage: the weighted difference
// and the slew step size. Configuration is written through a plain write port
// while the block is idle; the user must ensure this, the block does not check.
// ----------------------------------------------------------------------------
// Zero crossing period tracker top level
// Sample input stage, per-wave metric tracking and result register.
// ----------------------------------------------------------------------------
`include "zero_crossing_period_tracker_top_macros.svh"

module zero_crossing_period_tracker_top
    import zcpt_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF,
    parameter int AVG_FRAC_BITS = AVG_FRAC_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    // configuration write port
    input  logic                                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                        i_cfg_index,
    input  logic [((COUNT_BITS+AVG_FRAC_BITS) > ALPHA_W ?
                   (COUNT_BITS+AVG_FRAC_BITS) : ALPHA_W)-1:0] i_cfg_data,
    // sample channel
    input  logic                                        i_in_valid,
    output logic                                        o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]               i_in_sample,
    // result channel
    output logic                                        o_out_valid,
    input  logic                                        i_out_stall,
    output logic [COUNT_BITS+AVG_FRAC_BITS-1:0]         o_out_avg_period,
    output logic                                        o_out_wave_done,
    output logic [COUNT_BITS-1:0]                       o_out_wave_len,
    output logic [COUNT_BITS-1:0]                       o_out_prev_wave_len,
    output logic [COUNT_BITS-1:0]                       o_out_pos_half_len,
    output logic [COUNT_BITS-1:0]                       o_out_neg_half_len,
    output logic [CLIP_W-1:0]                           o_out_clip_hits,
    output logic [SUM_W-1:0]                            o_out_full_sq_sum,
    output logic [SUM_W-1:0]                            o_out_pos_sq_sum,
    output logic [SUM_W-1:0]                            o_out_neg_sq_sum,
    output logic [SAMPLE_BITS-2:0]                      o_out_peak_high,
    output logic signed [SAMPLE_BITS-1:0]               o_out_peak_low
);

    localparam int AW    = COUNT_BITS + AVG_FRAC_BITS;
    localparam int SB    = SAMPLE_BITS;
    localparam logic signed [SB-1:0] SMP_MAXV = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SMP_MINV = {1'b1, {(SB-1){1'b0}}};

    // configuration registers
    logic [ALPHA_W-1:0]         r_alpha;
    logic [AW-1:0]              r_thresh;
    logic [AW-1:0]              r_slew;
    logic [AW-1:0]              r_gap_limit;
    logic [GAP_W-1:0]           r_max_run;
    logic                       r_metrics_en;

    // input stage
    logic                       r_in_valid;
    logic signed [SB-1:0]       r_in_sample;
    logic [SUM_W-1:0]           r_in_sq;
    logic signed [2*SB-1:0]     sq_prod;
    logic                       in_accept;
    logic                       out_free;
    logic                       fire;

    // per-wave state
    logic signed [SB-1:0]       r_prev;
    logic [COUNT_BITS-1:0]      r_count;
    logic [COUNT_BITS-1:0]      r_neg_len;
    logic [COUNT_BITS-1:0]      r_last;
    logic [SUM_W-1:0]           r_half_sq;
    logic [SUM_W-1:0]           r_neg_sq;
    logic signed [SB-1:0]       r_max;
    logic signed [SB-1:0]       r_min;
    logic [CLIP_W-1:0]          r_clip;

    logic signed [SB-1:0]       n_prev;
    logic [COUNT_BITS-1:0]      n_count;
    logic [COUNT_BITS-1:0]      n_neg_len;
    logic [COUNT_BITS-1:0]      n_last;
    logic [SUM_W-1:0]           n_half_sq;
    logic [SUM_W-1:0]           n_neg_sq;
    logic signed [SB-1:0]       n_max;
    logic signed [SB-1:0]       n_min;
    logic [CLIP_W-1:0]          n_clip;

    // result-stage logic
    logic                       s_pos;
    logic                       s_neg;
    logic                       up_x;
    logic                       dn_x;
    logic                       wave_done;
    logic [SUM_W:0]             acc_sum;
    logic [SUM_W-1:0]           acc1;
    logic [SUM_W:0]             full_sum;
    logic [SUM_W-1:0]           full_sq;
    logic signed [SB-1:0]       max1;
    logic signed [SB-1:0]       min1;
    logic                       clip_hit;
    logic [CLIP_W-1:0]          clip1;
    logic [COUNT_BITS-1:0]      pos_len;
    logic [AW-1:0]              avg_next;

    // result register
    logic                       r_out_valid;
    logic [AW-1:0]              r_out_avg;
    logic                       r_out_done;
    logic [COUNT_BITS-1:0]      r_out_wave_len;
    logic [COUNT_BITS-1:0]      r_out_prev_len;
    logic [COUNT_BITS-1:0]      r_out_pos_len;
    logic [COUNT_BITS-1:0]      r_out_neg_len;
    logic [CLIP_W-1:0]          r_out_clip;
    logic [SUM_W-1:0]           r_out_full_sq;
    logic [SUM_W-1:0]           r_out_pos_sq;
    logic [SUM_W-1:0]           r_out_neg_sq;
    logic [SB-2:0]              r_out_peak_high;
    logic signed [SB-1:0]       r_out_peak_low;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha      <= ALPHA_W'(ALPHA_RST);
            r_thresh     <= AW'(THRESH_RST);
            r_slew       <= AW'(SLEW_RST);
            r_gap_limit  <= AW'(GAP_LIMIT_RST);
            r_max_run    <= GAP_W'(MAX_RUN_RST);
            r_metrics_en <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ALPHA:     r_alpha      <= i_cfg_data[ALPHA_W-1:0];
                CFG_THRESH:    r_thresh     <= i_cfg_data[AW-1:0];
                CFG_SLEW:      r_slew       <= i_cfg_data[AW-1:0];
                CFG_GAP_LIMIT: r_gap_limit  <= i_cfg_data[AW-1:0];
                CFG_MAX_RUN:   r_max_run    <= i_cfg_data[GAP_W-1:0];
                CFG_METRICS:   r_metrics_en <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Handshake: the result register frees when empty or being taken
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Square the sample on its way into the input register
    assign sq_prod = i_in_sample * i_in_sample;

    // Hold the accepted sample until the result stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_sample <= i_in_sample;
            r_in_sq     <= SUM_W'($unsigned(sq_prod));
        end
    end

    // Classify the sample and the crossings
    assign s_pos = !r_in_sample[SB-1] && (|r_in_sample);
    assign s_neg = r_in_sample[SB-1];
    assign up_x  = r_prev[SB-1] && !s_neg;
    assign dn_x  = !r_prev[SB-1] && (|r_prev) && !s_pos;
    assign wave_done = dn_x && r_metrics_en;

    // Accumulate metrics for this sample, saturating
    assign acc_sum = {1'b0, r_half_sq} + {1'b0, r_in_sq};
    assign acc1    = !r_metrics_en ? r_half_sq :
                     (acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0]);
    assign max1    = (r_metrics_en && s_pos && (r_in_sample > r_max)) ? r_in_sample : r_max;
    assign min1    = (r_metrics_en && s_neg && (r_in_sample < r_min)) ? r_in_sample : r_min;
    assign clip_hit = (r_in_sample == SMP_MINV) || (r_in_sample == SMP_MAXV);
    assign clip1   = (r_metrics_en && clip_hit && (r_clip != {CLIP_W{1'b1}})) ?
                     (r_clip + CLIP_W'(1)) : r_clip;

    // Wave results at a down crossing
    assign pos_len  = (r_count > r_neg_len) ? (r_count - r_neg_len) : '0;
    assign full_sum = {1'b0, acc1} + {1'b0, r_neg_sq};
    assign full_sq  = full_sum[SUM_W] ? {SUM_W{1'b1}} : full_sum[SUM_W-1:0];

    // Advance per-wave state
    always_comb begin
        n_prev    = r_in_sample;
        n_neg_len = up_x ? r_count : r_neg_len;
        n_neg_sq  = up_x ? acc1 : (dn_x ? '0 : r_neg_sq);
        n_half_sq = (up_x || dn_x) ? '0 : acc1;
        n_max     = dn_x ? '0 : max1;
        n_min     = dn_x ? '0 : min1;
        n_clip    = dn_x ? '0 : clip1;
        n_last    = dn_x ? r_count : r_last;
        if (dn_x) begin
            n_count = COUNT_BITS'(1);
        end else if (r_count != {COUNT_BITS{1'b1}}) begin
            n_count = r_count + COUNT_BITS'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_count   <= '0;
            r_neg_len <= '0;
            r_last    <= '0;
            r_half_sq <= '0;
            r_neg_sq  <= '0;
            r_max     <= '0;
            r_min     <= '0;
            r_clip    <= '0;
        end else if (fire) begin
            r_prev    <= n_prev;
            r_count   <= n_count;
            r_neg_len <= n_neg_len;
            r_last    <= n_last;
            r_half_sq <= n_half_sq;
            r_neg_sq  <= n_neg_sq;
            r_max     <= n_max;
            r_min     <= n_min;
            r_clip    <= n_clip;
        end
    end

    // Update the smoothed period at each down crossing
    zcpt_avg #(
        .COUNT_BITS    (COUNT_BITS),
        .AVG_FRAC_BITS (AVG_FRAC_BITS)
    ) u_avg (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_update           (fire && dn_x),
        .i_period           (r_count),
        .i_alpha            (r_alpha),
        .i_change_threshold (r_thresh),
        .i_slew_step        (r_slew),
        .i_gap_limit        (r_gap_limit),
        .i_max_gap_run      (r_max_run),
        .o_avg_next         (avg_next)
    );

    // Load the result register; clear when the transaction is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_avg       <= avg_next;
            r_out_done      <= wave_done;
            r_out_wave_len  <= wave_done ? r_count : '0;
            r_out_prev_len  <= wave_done ? r_last : '0;
            r_out_pos_len   <= wave_done ? pos_len : '0;
            r_out_neg_len   <= wave_done ? r_neg_len : '0;
            r_out_clip      <= wave_done ? clip1 : '0;
            r_out_full_sq   <= wave_done ? full_sq : '0;
            r_out_pos_sq    <= wave_done ? acc1 : '0;
            r_out_neg_sq    <= wave_done ? r_neg_sq : '0;
            r_out_peak_high <= wave_done ? max1[SB-2:0] : '0;
            r_out_peak_low  <= wave_done ? min1 : '0;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_avg_period    = r_out_avg;
    assign o_out_wave_done     = r_out_done;
    assign o_out_wave_len      = r_out_wave_len;
    assign o_out_prev_wave_len = r_out_prev_len;
    assign o_out_pos_half_len  = r_out_pos_len;
    assign o_out_neg_half_len  = r_out_neg_len;
    assign o_out_clip_hits     = r_out_clip;
    assign o_out_full_sq_sum   = r_out_full_sq;
    assign o_out_pos_sq_sum    = r_out_pos_sq;
    assign o_out_neg_sq_sum    = r_out_neg_sq;
    assign o_out_peak_high     = r_out_peak_high;
    assign o_out_peak_low      = r_out_peak_low;

    `ZCPT_ASSERT_SAME(a_avg_out_nonzero, i_clk, i_rst_n, o_out_valid,
        o_out_avg_period != '0, "result carries a zero average")
    `ZCPT_ASSERT_SAME(a_idle_fields_zero, i_clk, i_rst_n, o_out_valid && !o_out_wave_done,
        (o_out_wave_len == '0) && (o_out_full_sq_sum == '0) && (o_out_clip_hits == '0),
        "metric fields set without a completed wave")
    `ZCPT_ASSERT_SAME(a_full_covers_pos, i_clk, i_rst_n, o_out_valid && o_out_wave_done,
        o_out_full_sq_sum >= o_out_pos_sq_sum, "full-wave sum below positive half sum")
    `ZCPT_ASSERT_NEVER(a_crossing_excl, i_clk, i_rst_n, up_x && dn_x,
        "up and down crossing on one sample")
    `ZCPT_ASSERT_NEXT(a_count_restart, i_clk, i_rst_n, i_rst_n && fire && dn_x,
        r_count == COUNT_BITS'(1), "period count not restarted after a crossing")

endmodule
